// ----- hdl/piorg_pkg.sv -----
// Package for the per-process I/O rate guard.
// Holds widths, command and status codes, controller states and command/status structs.
// No dependencies.
`default_nettype none
package piorg_pkg;

	localparam int unsigned SLOTS      = 1024;
	localparam int unsigned SLOT_W     = $clog2(SLOTS);
	localparam int unsigned USED_W     = SLOT_W + 1;
	localparam int unsigned PID_W      = 22;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned SUM_W      = 64;
	localparam int unsigned CFG_IDX_W  = 1;
	// Slot record: owner, freed, write/read/other tallies, byte sums.
	localparam int unsigned REC_W      = PID_W + 1 + 3 * CNT_W + 2 * SUM_W;

	localparam logic [CNT_W-1:0] THRESH_RST = 32'd500000;
	localparam logic [CNT_W-1:0] PERIOD_RST = 32'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_IO_THRESHOLD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 1'd1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_OTHER = 2'd2,
		CMD_ALT   = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_EXISTING = 2'd0;
	localparam logic [1:0] ST_NEW      = 2'd1;
	localparam logic [1:0] ST_DROPPED  = 2'd2;

	typedef struct packed {
		logic [PID_W-1:0] owner;
		logic             freed;
		logic [CNT_W-1:0] wr_cnt;
		logic [CNT_W-1:0] rd_cnt;
		logic [CNT_W-1:0] ot_cnt;
		logic [SUM_W-1:0] wr_sum;
		logic [SUM_W-1:0] rd_sum;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_READ,
		S_UPDATE,
		S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // capture input item
		logic scan_start; // reset scan index, issue read of slot 0
		logic scan_step;  // evaluate read data, advance index
		logic decide;     // choose slot
		logic rd_issue;   // read chosen slot
		logic update;     // compute and write back, build result
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic hit;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/piorg_if.sv -----
// Valid/ready channel interfaces for the rate guard.
// Depends on piorg_pkg.
`default_nettype none
interface piorg_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [piorg_pkg::PID_W-1:0]   proc_id;
	logic [piorg_pkg::CNT_W-1:0]   access_bytes;
	modport source (output valid, cmd, proc_id, access_bytes, input ready);
	modport sink (input valid, cmd, proc_id, access_bytes, output ready);
endinterface

interface piorg_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [9:0]                    slot;
	logic                          kill;
	logic [piorg_pkg::CNT_W-1:0]   write_total;
	logic [piorg_pkg::CNT_W-1:0]   read_total;
	logic [piorg_pkg::CNT_W-1:0]   other_total;
	logic [piorg_pkg::SUM_W-1:0]   bytes_written;
	logic [piorg_pkg::SUM_W-1:0]   bytes_read;
	logic                          report_due;
	modport source (output valid, status, slot, kill, write_total, read_total, other_total,
		bytes_written, bytes_read, report_due, input ready);
	modport sink (input valid, status, slot, kill, write_total, read_total, other_total,
		bytes_written, bytes_read, report_due, output ready);
endinterface

interface piorg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [piorg_pkg::CFG_IDX_W-1:0]   index;
	logic [piorg_pkg::CNT_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/per_process_io_rate_guard_top.sv -----
// Per-process I/O rate guard.
// Channels: "ev" carries one event item (cmd, proc_id, access_bytes) per handshake;
// "res" returns exactly one result item per event; "cfg" writes io_threshold (index 0)
// or report_period (index 1). Write only while the block is idle; it does not check.
// Sequence: an event scans the live slots one per cycle from the slot record RAM,
// stopping at the owner's slot or past the last live slot, scanning 1 up to SLOTS
// (1024 at most); decide, read and update states follow, then the result is valid.
// Throughput: one item at a time; the scan over the record RAM's single port sets the
// rate, so the next item is accepted only after the result is taken, when the block
// is idle again.
// Reset: slot count and report counter clear at once; the record RAM needs no clearing
// because only claimed slots are ever read. Both registers return to their defaults.
// Stall: when res.ready is low the result is held in its register and ev.ready stays
// low until the result is taken. cfg.ready is always high.
// Depends on piorg_pkg, piorg_if, piorg_ram, piorg_ctrl and piorg_dp.
`default_nettype none
module per_process_io_rate_guard_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	piorg_in_if.sink   ev,
	piorg_out_if.source res,
	piorg_cfg_if.sink  cfg
);
	piorg_pkg::dp_cmd_t dcmd;
	piorg_pkg::dp_sts_t dsts;
	logic [piorg_pkg::CNT_W-1:0] thresh_q;
	logic [piorg_pkg::CNT_W-1:0] period_cfg_q;

	// Configuration registers: always ready.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= piorg_pkg::THRESH_RST;
			period_cfg_q <= piorg_pkg::PERIOD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				piorg_pkg::REG_IO_THRESHOLD:  thresh_q     <= cfg.data;
				piorg_pkg::REG_REPORT_PERIOD: period_cfg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	piorg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ev.valid),
		.in_ready  (ev.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (dcmd),
		.sts       (dsts)
	);

	piorg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dcmd),
		.sts           (dsts),
		.in_cmd        (ev.cmd),
		.in_pid        (ev.proc_id),
		.in_bytes      (ev.access_bytes),
		.io_threshold  (thresh_q),
		.report_period (period_cfg_q),
		.status        (res.status),
		.slot          (res.slot),
		.kill          (res.kill),
		.write_total   (res.write_total),
		.read_total    (res.read_total),
		.other_total   (res.other_total),
		.bytes_written (res.bytes_written),
		.bytes_read    (res.bytes_read),
		.report_due    (res.report_due)
	);

`ifndef ASSERT_OFF
	// No new item while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !ev.ready) else $error("item accepted while result pending");
	// A dropped event reports no kill.
	a_drop_nokill: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == piorg_pkg::ST_DROPPED) |-> !res.kill)
		else $error("kill on dropped event");
	// Controller issues at most one of scan step, decide, read and update at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dcmd.scan_step, dcmd.decide, dcmd.rd_issue, dcmd.update}))
		else $error("overlapping datapath commands");
`endif
endmodule
`default_nettype wire

// ----- hdl/piorg_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module piorg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hdl/piorg_ctrl.sv -----
// Controller state machine for the rate guard: sequences scan, choice, update, output.
// Depends on piorg_pkg.
`default_nettype none
module piorg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output piorg_pkg::dp_cmd_t       cmd,
	input  wire piorg_pkg::dp_sts_t  sts
);
	piorg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= piorg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			piorg_pkg::S_IDLE:   if (in_valid) state_d = piorg_pkg::S_SCAN;
			piorg_pkg::S_SCAN:   if (sts.hit || sts.scan_done) state_d = piorg_pkg::S_DECIDE;
			piorg_pkg::S_DECIDE: state_d = piorg_pkg::S_READ;
			piorg_pkg::S_READ:   state_d = piorg_pkg::S_UPDATE;
			piorg_pkg::S_UPDATE: state_d = piorg_pkg::S_OUT;
			piorg_pkg::S_OUT:    if (out_ready) state_d = piorg_pkg::S_IDLE;
			default:             state_d = piorg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			piorg_pkg::S_IDLE: begin
				in_ready       = 1'b1;
				cmd.load       = in_valid;
				cmd.scan_start = in_valid;
			end
			piorg_pkg::S_SCAN:   cmd.scan_step = 1'b1;
			piorg_pkg::S_DECIDE: cmd.decide    = 1'b1;
			piorg_pkg::S_READ:   cmd.rd_issue  = 1'b1;
			piorg_pkg::S_UPDATE: cmd.update    = 1'b1;
			piorg_pkg::S_OUT:    out_valid     = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/piorg_dp.sv -----
// Datapath for the rate guard: slot record RAM, scan index, counters, result register.
// Depends on piorg_pkg and piorg_ram.
`default_nettype none
module piorg_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire piorg_pkg::dp_cmd_t             cmd,
	output piorg_pkg::dp_sts_t                  sts,
	input  wire logic [1:0]                     in_cmd,
	input  wire logic [piorg_pkg::PID_W-1:0]    in_pid,
	input  wire logic [piorg_pkg::CNT_W-1:0]    in_bytes,
	input  wire logic [piorg_pkg::CNT_W-1:0]    io_threshold,
	input  wire logic [piorg_pkg::CNT_W-1:0]    report_period,
	output logic [1:0]                          status,
	output logic [9:0]                          slot,
	output logic                                kill,
	output logic [piorg_pkg::CNT_W-1:0]         write_total,
	output logic [piorg_pkg::CNT_W-1:0]         read_total,
	output logic [piorg_pkg::CNT_W-1:0]         other_total,
	output logic [piorg_pkg::SUM_W-1:0]         bytes_written,
	output logic [piorg_pkg::SUM_W-1:0]         bytes_read,
	output logic                                report_due
);
	localparam int unsigned SW = piorg_pkg::SLOT_W;
	localparam int unsigned UW = piorg_pkg::USED_W;
	localparam logic [piorg_pkg::CNT_W-1:0] MAXC = '1;

	logic [1:0]                   cmd_q;
	logic [piorg_pkg::PID_W-1:0]  pid_q;
	logic [piorg_pkg::CNT_W-1:0]  bytes_q;
	logic [UW-1:0]                used_q;
	logic [piorg_pkg::CNT_W-1:0]  period_q;
	logic [UW-1:0]                idx_q;     // slot whose data arrives this cycle
	logic                         hit_q;
	logic                         free_ok_q;
	logic [SW-1:0]                free_q;
	logic [SW-1:0]                sel_q;
	logic [SW-1:0]                hit_slot_q;
	logic [1:0]                   st_q;

	logic [SW-1:0]                ram_addr;
	logic                         ram_we;
	piorg_pkg::rec_t              ram_wdata, ram_rdata, rec;
	logic                         cur_valid;
	logic                         cur_hit;
	logic                         is_rw;
	logic [piorg_pkg::CNT_W-1:0]  nxt_period;
	logic                         kill_now;

	piorg_ram #(.WIDTH(piorg_pkg::REC_W), .DEPTH(piorg_pkg::SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign is_rw     = (cmd_q == piorg_pkg::CMD_WRITE) || (cmd_q == piorg_pkg::CMD_READ);
	assign cur_valid = idx_q < used_q;
	assign cur_hit   = cur_valid && !ram_rdata.freed && (ram_rdata.owner == pid_q);
	assign sts.hit       = cur_hit;
	assign sts.scan_done = !cur_valid || (idx_q == UW'(piorg_pkg::SLOTS - 1));

	// Address: during scan read the next slot; otherwise the chosen slot.
	always_comb begin
		if (cmd.scan_start) begin
			ram_addr = '0;
		end else if (cmd.scan_step) begin
			ram_addr = SW'(idx_q + UW'(1));
		end else begin
			ram_addr = sel_q;
		end
	end

	// Fresh record when a slot is (re)claimed; then bump the command's tally and byte sum.
	always_comb begin
		rec = ram_rdata;
		if (st_q == piorg_pkg::ST_NEW) begin
			rec        = '0;
			rec.owner  = pid_q;
		end
		unique case (cmd_q)
			piorg_pkg::CMD_WRITE: begin
				rec.wr_cnt = (rec.wr_cnt == MAXC) ? rec.wr_cnt : rec.wr_cnt + 1'b1;
				rec.wr_sum = rec.wr_sum + piorg_pkg::SUM_W'(bytes_q);
			end
			piorg_pkg::CMD_READ: begin
				rec.rd_cnt = (rec.rd_cnt == MAXC) ? rec.rd_cnt : rec.rd_cnt + 1'b1;
				rec.rd_sum = rec.rd_sum + piorg_pkg::SUM_W'(bytes_q);
			end
			default: rec.ot_cnt = (rec.ot_cnt == MAXC) ? rec.ot_cnt : rec.ot_cnt + 1'b1;
		endcase
	end

	assign kill_now = is_rw && (rec.wr_cnt > io_threshold) && (rec.rd_cnt > io_threshold);

	always_comb begin
		ram_wdata = rec;
		if (kill_now) begin
			ram_wdata.freed  = 1'b1;
			ram_wdata.wr_cnt = '0;
			ram_wdata.rd_cnt = '0;
		end
	end
	assign ram_we = cmd.update && (st_q != piorg_pkg::ST_DROPPED);

	assign nxt_period = period_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			period_q <= '0;
		end else begin
			if (cmd.decide && !hit_q && !free_ok_q && (used_q < UW'(piorg_pkg::SLOTS))) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.update && is_rw) begin
				period_q <= (nxt_period >= report_period) ? '0 : nxt_period;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			pid_q   <= in_pid;
			bytes_q <= in_bytes;
		end
		if (cmd.scan_start) begin
			idx_q     <= '0;
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cur_hit) begin
				hit_q      <= 1'b1;
				hit_slot_q <= SW'(idx_q);
			end
			if (cur_valid && ram_rdata.freed && !free_ok_q) begin
				free_ok_q <= 1'b1;
				free_q    <= SW'(idx_q);
			end
		end
		if (cmd.decide) begin
			priority if (hit_q) begin
				sel_q <= hit_slot_q;
				st_q  <= piorg_pkg::ST_EXISTING;
			end else if (free_ok_q) begin
				sel_q <= free_q;
				st_q  <= piorg_pkg::ST_NEW;
			end else if (used_q < UW'(piorg_pkg::SLOTS)) begin
				sel_q <= SW'(used_q);
				st_q  <= piorg_pkg::ST_NEW;
			end else begin
				sel_q <= '0;
				st_q  <= piorg_pkg::ST_DROPPED;
			end
		end
		if (cmd.update) begin
			status     <= st_q;
			report_due <= is_rw && (nxt_period >= report_period);
			if (st_q == piorg_pkg::ST_DROPPED) begin
				slot          <= '0;
				kill          <= 1'b0;
				write_total   <= '0;
				read_total    <= '0;
				other_total   <= '0;
				bytes_written <= '0;
				bytes_read    <= '0;
			end else begin
				slot          <= 10'(sel_q);
				kill          <= kill_now;
				write_total   <= rec.wr_cnt;
				read_total    <= rec.rd_cnt;
				other_total   <= rec.ot_cnt;
				bytes_written <= rec.wr_sum;
				bytes_read    <= rec.rd_sum;
			end
		end
	end
endmodule
`default_nettype wire

// ----- test/tb_guard_pkg.sv -----
`timescale 1ns / 100ps
// Shadow model and result checker for the per-process I/O rate guard testbench.
// Depends on piorg_pkg.
package tb_guard_pkg;
	import piorg_pkg::*;

	typedef struct packed {
		logic [1:0]       status;
		logic [9:0]       slot;
		logic             kill;
		logic [CNT_W-1:0] write_total;
		logic [CNT_W-1:0] read_total;
		logic [CNT_W-1:0] other_total;
		logic [SUM_W-1:0] bytes_written;
		logic [SUM_W-1:0] bytes_read;
		logic             report_due;
	} verdict_t;

	class guard_scoreboard;
		logic [CNT_W-1:0] threshold;
		logic [CNT_W-1:0] period;
		logic [PID_W-1:0] owner [SLOTS];
		bit               freed [SLOTS];
		int unsigned      claimed;
		logic [CNT_W-1:0] wr_cnt [SLOTS];
		logic [CNT_W-1:0] rd_cnt [SLOTS];
		logic [CNT_W-1:0] ot_cnt [SLOTS];
		logic [SUM_W-1:0] wr_sum [SLOTS];
		logic [SUM_W-1:0] rd_sum [SLOTS];
		logic [CNT_W-1:0] rw_events;
		verdict_t         pending [$];
		int unsigned      mismatches;

		function new();
			threshold = THRESH_RST;
			period = PERIOD_RST;
			claimed = 0;
			rw_events = '0;
			mismatches = 0;
			foreach (freed[i]) freed[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
			if (idx == REG_IO_THRESHOLD) threshold = val;
			else period = val;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		// Predict the result of one accepted event and queue it.
		function void note_event(logic [1:0] cmd, logic [PID_W-1:0] pid,
				logic [CNT_W-1:0] nbytes);
			verdict_t v;
			int s;
			bit hit, rw;
			v = '0;
			s = 0;
			hit = 0;
			rw = (cmd == CMD_WRITE) || (cmd == CMD_READ);
			for (int i = 0; i < claimed; i++)
				if (!hit && !freed[i] && owner[i] == pid) begin
					s = i;
					hit = 1;
				end
			v.status = ST_EXISTING;
			if (!hit) begin
				for (int i = 0; i < claimed; i++)
					if (!hit && freed[i]) begin
						s = i;
						hit = 1;
					end
				if (!hit && claimed < SLOTS) begin
					s = claimed;
					claimed++;
					hit = 1;
				end
				if (hit) begin
					owner[s] = pid;
					freed[s] = 0;
					wr_cnt[s] = '0;
					rd_cnt[s] = '0;
					ot_cnt[s] = '0;
					wr_sum[s] = '0;
					rd_sum[s] = '0;
					v.status = ST_NEW;
				end else
					v.status = ST_DROPPED;
			end
			if (hit) begin
				if (cmd == CMD_WRITE) begin
					wr_cnt[s] = bump(wr_cnt[s]);
					wr_sum[s] = wr_sum[s] + nbytes;
				end else if (cmd == CMD_READ) begin
					rd_cnt[s] = bump(rd_cnt[s]);
					rd_sum[s] = rd_sum[s] + nbytes;
				end else
					ot_cnt[s] = bump(ot_cnt[s]);
				v.slot = s[9:0];
				v.write_total = wr_cnt[s];
				v.read_total = rd_cnt[s];
				v.other_total = ot_cnt[s];
				v.bytes_written = wr_sum[s];
				v.bytes_read = rd_sum[s];
				if (rw && wr_cnt[s] > threshold && rd_cnt[s] > threshold) begin
					v.kill = 1;
					freed[s] = 1;
					wr_cnt[s] = '0;
					rd_cnt[s] = '0;
				end
			end
			if (rw) begin
				rw_events = rw_events + 1;
				if (rw_events >= period) begin
					v.report_due = 1;
					rw_events = '0;
				end
			end
			pending.push_back(v);
		endfunction

		function void check_result(verdict_t got);
			verdict_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch\n  expected %p\n  actual   %p", want, got);
			end
		endfunction
	endclass
endpackage

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for per_process_io_rate_guard_top: directed and random events,
// register phases, random stalls on both channels. Depends on piorg_pkg, piorg_if,
// tb_guard_pkg and the RTL.
module tb_top;
	import piorg_pkg::*;
	import tb_guard_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int unsigned cycles = 0;

	piorg_in_if  ev ();
	piorg_out_if res ();
	piorg_cfg_if cfg ();

	per_process_io_rate_guard_top u_top (
		.clk(clk), .arst_n(arst_n), .ev(ev.sink), .res(res.source), .cfg(cfg.sink)
	);

	guard_scoreboard board;
	int hold_cycles = 0;  // nonzero: force a long receiver hold-off
	bit stall_on = 1;     // random receiver stalls enabled
	int unsigned accepted_events = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		ev.valid = 0;
		ev.cmd = CMD_WRITE;
		ev.proc_id = '0;
		ev.access_bytes = '0;
		res.ready = 0;
		cfg.valid = 0;
		cfg.index = REG_IO_THRESHOLD;
		cfg.data = '0;
		board = new();
	end

	// Bound the run: fail once the cycle count passes the limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("per_process_io_rate_guard_top regression: fail");
			$finish;
		end
	end

	// Receiver: stall on its own pattern, with a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res.ready <= 0;
		end else if (!stall_on)
			res.ready <= 1;
		else
			res.ready <= ($urandom_range(0, 3) != 0);
		if (res.valid && res.ready)
			board.check_result('{res.status, res.slot, res.kill, res.write_total,
				res.read_total, res.other_total, res.bytes_written, res.bytes_read,
				res.report_due});
	end

	// Offer one event and hold it until accepted; note it on acceptance.
	task automatic send_event(logic [1:0] cmd, logic [PID_W-1:0] pid,
			logic [CNT_W-1:0] nbytes);
		ev.valid <= 1;
		ev.cmd <= cmd;
		ev.proc_id <= pid;
		ev.access_bytes <= nbytes;
		do @(posedge clk); while (!ev.ready);
		board.note_event(cmd, pid, nbytes);
		accepted_events++;
	endtask

	task automatic idle_cycles(int n);
		ev.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every expected result is in, then let the block settle.
	task automatic drain();
		ev.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		board.set_reg(idx, val);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [1:0] pick_cmd();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return CMD_WRITE;
		if (r < 8) return CMD_READ;
		if (r == 8) return CMD_OTHER;
		return CMD_ALT;
	endfunction

	// Random phase: bursts from a small pool of ids so slots hit, fill and get killed.
	task automatic random_phase(int n, int pool, logic [PID_W-1:0] base);
		logic [PID_W-1:0] pid;
		logic [CNT_W-1:0] nb;
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				if ($urandom_range(0, 15) == 0) pid = $urandom;
				else pid = base + $urandom_range(0, pool - 1);
				case ($urandom_range(0, 3))
					0: nb = $urandom;
					1: nb = '1;
					default: nb = $urandom_range(0, 4096);
				endcase
				send_event(pick_cmd(), pid, nb);
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 40));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every command, extreme ids and byte counts.
		write_reg(REG_IO_THRESHOLD, 32'd1);
		write_reg(REG_REPORT_PERIOD, 32'd3);
		send_event(CMD_WRITE, '0, '0);
		send_event(CMD_WRITE, '1, '1);
		send_event(CMD_READ, '1, '1);
		send_event(CMD_OTHER, '1, 32'h5555_5555);
		send_event(CMD_ALT, '0, 32'hAAAA_AAAA);
		send_event(CMD_READ, 22'h2A_AAAA, 32'hAAAA_AAAA);
		send_event(CMD_WRITE, 22'h15_5555, 32'h5555_5555);
		// Push id '1 over a threshold of one on both counts: kill, slot freed.
		send_event(CMD_WRITE, '1, '1);
		send_event(CMD_READ, '1, '1);
		// Freed slot is reused by a fresh id.
		send_event(CMD_OTHER, 22'h00_0123, 32'd7);
		send_event(CMD_READ, 22'h00_0123, 32'd7);
		drain();

		// Threshold zero kills on the first read after a write; period zero acts as one.
		write_reg(REG_IO_THRESHOLD, 32'd0);
		write_reg(REG_REPORT_PERIOD, 32'd0);
		send_event(CMD_WRITE, 22'h3F_0000, 32'd1);
		send_event(CMD_READ, 22'h3F_0000, 32'd1);
		send_event(CMD_OTHER, 22'h3F_0000, 32'd1);
		drain();

		// Fresh ids with no kills and a report period of seven, receiver ready while sending.
		write_reg(REG_IO_THRESHOLD, '1);
		write_reg(REG_REPORT_PERIOD, 32'd7);
		stall_on = 0;
		send_event(CMD_WRITE, 22'h10_0000, 32'd9);
		send_event(CMD_READ, 22'h10_0001, 32'd9);
		send_event(CMD_OTHER, 22'h10_0002, 32'd9);
		stall_on = 1;
		drain();

		// Long receiver hold-off while events keep coming, then pause until drained.
		fork
			hold_cycles = 400;
			random_phase(20, 64, 22'h20_0000);
		join
		drain();

		// Random phases over several register settings; low thresholds free slots
		// and let new ids reuse them.
		write_reg(REG_IO_THRESHOLD, 32'd2);
		write_reg(REG_REPORT_PERIOD, 32'd1);
		random_phase(200, 24, 22'h20_0000);
		drain();
		write_reg(REG_IO_THRESHOLD, 32'd0);
		write_reg(REG_REPORT_PERIOD, $urandom_range(2, 50));
		random_phase(200, 16, 22'h20_0100);
		drain();
		write_reg(REG_IO_THRESHOLD, $urandom_range(3, 8));
		write_reg(REG_REPORT_PERIOD, '1);
		random_phase(140, 32, 22'h20_0000);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("per_process_io_rate_guard_top regression: pass");
		else
			$display("per_process_io_rate_guard_top regression: fail");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/piorg_pkg.sv
hdl/piorg_if.sv
hdl/piorg_ram.sv
hdl/piorg_ctrl.sv
hdl/piorg_dp.sv
hdl/per_process_io_rate_guard_top.sv
test/tb_guard_pkg.sv
test/tb_top.sv
